// ----- src/thfc_pkg.sv -----
// Shared types and constants for the TCP header filter / frame counter.
// No dependencies; imported by every module of the block.
package thfc_pkg;

  // Offset of the IPv4 header inside the frame (link header length)
  localparam int unsigned LINK_HEADER_BYTES = 14;
  localparam logic [7:0]  PROTO_TCP         = 8'd6;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned OUT_DW = 104;  // 98 field bits padded to whole bytes

  // Offsets of the captured header bytes, relative to the frame start
  localparam logic [POS_W-1:0] POS_IHL      = POS_W'(LINK_HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_PROTO    = POS_W'(LINK_HEADER_BYTES + 9);
  localparam logic [POS_W-1:0] POS_SRC_LO   = POS_W'(LINK_HEADER_BYTES + 12);
  localparam logic [POS_W-1:0] POS_SRC_HI   = POS_W'(LINK_HEADER_BYTES + 15);
  localparam logic [POS_W-1:0] POS_DST_LO   = POS_W'(LINK_HEADER_BYTES + 16);
  localparam logic [POS_W-1:0] POS_DST_HI   = POS_W'(LINK_HEADER_BYTES + 19);
  localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SRC_ADDR_EN  = 3'd0,
    REG_SRC_ADDR_VAL = 3'd1,
    REG_DST_ADDR_EN  = 3'd2,
    REG_DST_ADDR_VAL = 3'd3,
    REG_SRC_PORT_EN  = 3'd4,
    REG_SRC_PORT_VAL = 3'd5,
    REG_DST_PORT_EN  = 3'd6,
    REG_DST_PORT_VAL = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic        src_addr_en;
    logic [31:0] src_addr;
    logic        dst_addr_en;
    logic [31:0] dst_addr;
    logic        src_port_en;
    logic [15:0] src_port;
    logic        dst_port_en;
    logic [15:0] dst_port;
  } filt_cfg_t;

  // Header fields of the frame as they stand after the current byte
  typedef struct packed {
    logic        is_tcp;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } frame_sum_t;

endpackage

// ----- src/thfc_parser.sv -----
// Per-byte header parser: tracks the byte position and captures IHL,
// protocol, IPv4 addresses and TCP ports. Depends on thfc_pkg.
module thfc_parser import thfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,       // a byte is processed this cycle
  input  logic [7:0] byte_in,
  input  logic       last_in,
  output frame_sum_t sum         // fields including the current byte
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]       ihl_r, ihl_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [31:0]      saddr_r, saddr_nxt;
  logic [31:0]      daddr_r, daddr_nxt;
  logic [15:0]      sport_r, sport_nxt;
  logic [15:0]      dport_r, dport_nxt;

  logic [POS_W:0]   tcp_start;
  logic [POS_W:0]   pos_ext;

  // Captures; the IHL taken from this byte already applies to it
  always_comb begin
    ihl_nxt   = (pos_r == POS_IHL)   ? byte_in[3:0] : ihl_r;
    proto_nxt = (pos_r == POS_PROTO) ? byte_in      : proto_r;
    saddr_nxt = (pos_r >= POS_SRC_LO && pos_r <= POS_SRC_HI) ?
                {saddr_r[23:0], byte_in} : saddr_r;
    daddr_nxt = (pos_r >= POS_DST_LO && pos_r <= POS_DST_HI) ?
                {daddr_r[23:0], byte_in} : daddr_r;

    pos_ext   = {1'b0, pos_r};
    tcp_start = (POS_W+1)'(LINK_HEADER_BYTES) + {{(POS_W-5){1'b0}}, ihl_nxt, 2'b00};

    sport_nxt = (pos_ext == tcp_start || pos_ext == tcp_start + 1'b1) ?
                {sport_r[7:0], byte_in} : sport_r;
    dport_nxt = (pos_ext == tcp_start + 2'd2 || pos_ext == tcp_start + 2'd3) ?
                {dport_r[7:0], byte_in} : dport_r;

    sum.is_tcp   = (proto_nxt == PROTO_TCP) && (pos_ext >= tcp_start + 2'd3);
    sum.src_addr = saddr_nxt;
    sum.dst_addr = daddr_nxt;
    sum.src_port = sport_nxt;
    sum.dst_port = dport_nxt;

    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
  end

  // Capture state; everything returns to zero after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last_in)) begin
      pos_r   <= '0;
      ihl_r   <= '0;
      proto_r <= '0;
      saddr_r <= '0;
      daddr_r <= '0;
      sport_r <= '0;
      dport_r <= '0;
    end else if (fire) begin
      pos_r   <= pos_nxt;
      ihl_r   <= ihl_nxt;
      proto_r <= proto_nxt;
      saddr_r <= saddr_nxt;
      daddr_r <= daddr_nxt;
      sport_r <= sport_nxt;
      dport_r <= dport_nxt;
    end
  end

endmodule

// ----- src/thfc_counter.sv -----
// Filter compare, saturating frame counters and the result register.
// Depends on thfc_pkg.
module thfc_counter import thfc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              frame_done,   // last byte processed this cycle
  input  frame_sum_t        sum,
  input  filt_cfg_t         cfg,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [OUT_DW-1:0] out_tdata
);

  logic [CNT_W-1:0] all_r, all_nxt;
  logic [CNT_W-1:0] tcp_r, tcp_nxt;
  logic [CNT_W-1:0] mat_r, mat_nxt;
  logic             is_tcp_r;
  logic             matched_r;
  logic             valid_r;
  logic             matched;

  // Every enabled field must equal its configured value
  always_comb begin
    matched = sum.is_tcp
            && (!cfg.src_addr_en || sum.src_addr == cfg.src_addr)
            && (!cfg.dst_addr_en || sum.dst_addr == cfg.dst_addr)
            && (!cfg.src_port_en || sum.src_port == cfg.src_port)
            && (!cfg.dst_port_en || sum.dst_port == cfg.dst_port);

    all_nxt = (&all_r) ? all_r : all_r + 1'b1;
    tcp_nxt = (sum.is_tcp && !(&tcp_r)) ? tcp_r + 1'b1 : tcp_r;
    mat_nxt = (matched && !(&mat_r)) ? mat_r + 1'b1 : mat_r;
  end

  // Counters and per-frame flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      all_r     <= '0;
      tcp_r     <= '0;
      mat_r     <= '0;
      is_tcp_r  <= 1'b0;
      matched_r <= 1'b0;
    end else if (frame_done) begin
      all_r     <= all_nxt;
      tcp_r     <= tcp_nxt;
      mat_r     <= mat_nxt;
      is_tcp_r  <= sum.is_tcp;
      matched_r <= matched;
    end
  end

  // Result valid; upstream only signals frame_done when this slot is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (frame_done) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, matched_r, is_tcp_r, mat_r, tcp_r, all_r};

endmodule

// ----- src/tcp_header_filter_counter.sv -----
// A byte accepted is held in the input register and parsed from there; a frame's
// result is registered onto out_* when its last byte leaves the input register,
// which waits while the result slot is full.
// Throughput: one byte per cycle; only a last byte waits on a stalled result.
// Reset (rst_n low, synchronous): counters, captures, config and valids clear.
// Top level: input register, config registers, parser and counter.
// Depends on thfc_pkg, thfc_parser, thfc_counter.
module tcp_header_filter_counter import thfc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,    // [7:0] frame_byte
  input  logic              in_tlast,    // frame_end
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,   // [31:0] all_frames, [63:32] tcp_frames,
                                         // [95:64] matched_frames, [96] frame_is_tcp,
                                         // [97] frame_matched, [103:98] zero
  // configuration writes
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [31:0]       cfg_wdata
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       proc_fire;
  logic       out_free;
  filt_cfg_t  cfg_r;
  frame_sum_t sum;

  // A last byte needs a free result slot; other bytes always move on
  assign out_free  = !out_tvalid || out_tready;
  assign proc_fire = in_valid_r && (!in_last_r || out_free);
  assign in_tready = !in_valid_r || proc_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_SRC_ADDR_EN:  cfg_r.src_addr_en <= cfg_wdata[0];
        REG_SRC_ADDR_VAL: cfg_r.src_addr    <= cfg_wdata;
        REG_DST_ADDR_EN:  cfg_r.dst_addr_en <= cfg_wdata[0];
        REG_DST_ADDR_VAL: cfg_r.dst_addr    <= cfg_wdata;
        REG_SRC_PORT_EN:  cfg_r.src_port_en <= cfg_wdata[0];
        REG_SRC_PORT_VAL: cfg_r.src_port    <= cfg_wdata[15:0];
        REG_DST_PORT_EN:  cfg_r.dst_port_en <= cfg_wdata[0];
        REG_DST_PORT_VAL: cfg_r.dst_port    <= cfg_wdata[15:0];
      endcase
    end
  end

  thfc_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (proc_fire),
    .byte_in (in_byte_r),
    .last_in (in_last_r),
    .sum     (sum)
  );

  thfc_counter u_counter (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_done (proc_fire && in_last_r),
    .sum        (sum),
    .cfg        (cfg_r),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- bench/tb_tcp_header_filter_counter.sv -----
// Self-checking bench for tcp_header_filter_counter: streams framed bytes and
// checks each frame report against a bit-accurate frame tally kept here.
// Depends on thfc_pkg and the tcp_header_filter_counter RTL.
`timescale 1ns / 100ps

module tb_tcp_header_filter_counter;
  import thfc_pkg::*;

  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int QUIET_LIMIT = 4000;  // cycles with no transaction before giving up
  localparam int SETTLE      = 8;     // cycles after the last report before a write
  localparam int FRAME_BUF   = 96;    // bytes built per frame; longer frames pad randomly
  localparam int BLOCK_BYTES = 95;    // minimum bytes per filter setting

  typedef enum {FILT_OFF, FILT_ALL, FILT_EXTREME, FILT_MIXED} filt_mode_e;

  // Frame report as packed on out_tdata, lowest bits last
  typedef struct packed {
    logic [5:0]  pad;
    logic        frame_matched;
    logic        frame_is_tcp;
    logic [31:0] matched_frames;
    logic [31:0] tcp_frames;
    logic [31:0] all_frames;
  } frame_report_t;

  // Scoreboard: tracks header captures and counters byte by byte
  class frame_tally;
    filt_cfg_t     filt;
    logic [15:0]   pos;
    logic [3:0]    ihl;
    logic [7:0]    proto;
    logic [31:0]   src_ip, dst_ip;
    logic [15:0]   src_port, dst_port;
    logic [31:0]   n_all, n_tcp, n_match;
    frame_report_t reports_due[$];
    int            errors;

    function new();
      filt    = '0;
      n_all   = '0;
      n_tcp   = '0;
      n_match = '0;
      errors  = 0;
      clear_capture();
    endfunction

    function void clear_capture();
      pos      = '0;
      ihl      = '0;
      proto    = '0;
      src_ip   = '0;
      dst_ip   = '0;
      src_port = '0;
      dst_port = '0;
    endfunction

    function logic [31:0] sat_inc(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] d);
      case (idx)
        REG_SRC_ADDR_EN:  filt.src_addr_en = d[0];
        REG_SRC_ADDR_VAL: filt.src_addr    = d;
        REG_DST_ADDR_EN:  filt.dst_addr_en = d[0];
        REG_DST_ADDR_VAL: filt.dst_addr    = d;
        REG_SRC_PORT_EN:  filt.src_port_en = d[0];
        REG_SRC_PORT_VAL: filt.src_port    = d[15:0];
        REG_DST_PORT_EN:  filt.dst_port_en = d[0];
        REG_DST_PORT_VAL: filt.dst_port    = d[15:0];
        default: ;
      endcase
    endfunction

    // One accepted input transaction
    function void take_byte(logic [7:0] b, logic last);
      int unsigned   p, tcp_at;
      logic          tcp, hit;
      frame_report_t rep;
      p = pos;
      if (p == LINK_HEADER_BYTES) ihl = b[3:0];
      if (p == LINK_HEADER_BYTES + 9) proto = b;
      if (p >= LINK_HEADER_BYTES + 12 && p <= LINK_HEADER_BYTES + 15)
        src_ip = {src_ip[23:0], b};
      if (p >= LINK_HEADER_BYTES + 16 && p <= LINK_HEADER_BYTES + 19)
        dst_ip = {dst_ip[23:0], b};
      // IHL taken from this very byte already moves the port window
      tcp_at = LINK_HEADER_BYTES + ihl * 4;
      if (p == tcp_at || p == tcp_at + 1) src_port = {src_port[7:0], b};
      if (p == tcp_at + 2 || p == tcp_at + 3) dst_port = {dst_port[7:0], b};
      if (!last) begin
        if (pos != 16'hFFFF) pos = pos + 16'd1;
        return;
      end
      tcp = (proto == PROTO_TCP) && (p >= tcp_at + 3);
      hit = tcp;
      if (filt.src_addr_en && src_ip != filt.src_addr) hit = 1'b0;
      if (filt.dst_addr_en && dst_ip != filt.dst_addr) hit = 1'b0;
      if (filt.src_port_en && src_port != filt.src_port) hit = 1'b0;
      if (filt.dst_port_en && dst_port != filt.dst_port) hit = 1'b0;
      n_all = sat_inc(n_all);
      if (tcp) n_tcp = sat_inc(n_tcp);
      if (hit) n_match = sat_inc(n_match);
      rep.pad            = '0;
      rep.frame_matched  = hit;
      rep.frame_is_tcp   = tcp;
      rep.matched_frames = n_match;
      rep.tcp_frames     = n_tcp;
      rep.all_frames     = n_all;
      reports_due.push_back(rep);
      clear_capture();
    endfunction

    function int unsigned pending();
      return reports_due.size();
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // One accepted output transaction
    function void check_report(frame_report_t got);
      frame_report_t want;
      if (reports_due.size() == 0) begin
        $error("unexpected frame report: %0h", got);
        errors++;
        return;
      end
      want = reports_due.pop_front();
      compare("all_frames", want.all_frames, got.all_frames);
      compare("tcp_frames", want.tcp_frames, got.tcp_frames);
      compare("matched_frames", want.matched_frames, got.matched_frames);
      compare("frame_is_tcp", want.frame_is_tcp, got.frame_is_tcp);
      compare("frame_matched", want.frame_matched, got.frame_matched);
      compare("pad", want.pad, got.pad);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic              cfg_we;
  logic [2:0]        cfg_addr;
  logic [31:0]       cfg_wdata;

  frame_tally  tally;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_reqs   = 0;
  int          holds_done  = 0;
  int          hold_left   = 0;
  int          quiet       = 0;
  logic [7:0]  frame_buf[FRAME_BUF];

  tcp_header_filter_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Receiver: random backpressure, plus long hold-offs on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_reqs != holds_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES - 1;
      holds_done <= holds_done + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitors: sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tally.take_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) tally.check_report(out_tdata);
    end
  end

  // Watchdog on stretches with no transaction at all
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_frame(int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_byte((i < FRAME_BUF) ? frame_buf[i] : 8'($urandom_range(255)), i == len - 1);
  endtask

  // Wait out every pending report, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (tally.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] d);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= d;
    tally.set_reg(idx, d);
    @(negedge clk);
  endtask

  // Enable bit in bit 0; upper bits are junk the block must mask off
  function automatic logic [31:0] enable_word(filt_mode_e mode);
    logic en;
    case (mode)
      FILT_OFF: en = 1'b0;
      FILT_ALL, FILT_EXTREME: en = 1'b1;
      default: en = 1'($urandom_range(1));
    endcase
    return {31'($urandom()), en};
  endfunction

  function automatic logic [31:0] value_word(filt_mode_e mode);
    if (mode == FILT_EXTREME) return $urandom_range(1) ? '1 : '0;
    return $urandom();
  endfunction

  task automatic apply_filter(filt_mode_e mode);
    write_reg(REG_SRC_ADDR_EN,  enable_word(mode));
    write_reg(REG_SRC_ADDR_VAL, value_word(mode));
    write_reg(REG_DST_ADDR_EN,  enable_word(mode));
    write_reg(REG_DST_ADDR_VAL, value_word(mode));
    write_reg(REG_SRC_PORT_EN,  enable_word(mode));
    write_reg(REG_SRC_PORT_VAL, value_word(mode));
    write_reg(REG_DST_PORT_EN,  enable_word(mode));
    write_reg(REG_DST_PORT_VAL, value_word(mode));
    cfg_we <= 1'b0;
  endtask

  // Mostly the configured value, sometimes extremes or a near miss
  function automatic logic [31:0] near_value(logic [31:0] v, int w);
    logic [31:0] mask;
    int          r;
    mask = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
    r = $urandom_range(99);
    if (r < 55) return v & mask;
    if (r < 65) return '0;
    if (r < 75) return mask;
    if (r < 85) return (v ^ (32'd1 << $urandom_range(w - 1))) & mask;
    return $urandom() & mask;
  endfunction

  // Fill frame_buf with one frame and pick its length
  task automatic build_frame(output int unsigned len);
    int unsigned hdr_words, tcp_at, r;
    logic [31:0] sa, da, sp, dp;
    for (int i = 0; i < FRAME_BUF; i++) frame_buf[i] = 8'($urandom_range(255));
    r = $urandom_range(99);
    if (r < 10) begin
      // unstructured noise
      len = $urandom_range(40, 1);
      return;
    end
    hdr_words = ($urandom_range(99) < 60) ? 5 : $urandom_range(15);
    tcp_at = LINK_HEADER_BYTES + hdr_words * 4;
    sa = near_value(tally.filt.src_addr, 32);
    da = near_value(tally.filt.dst_addr, 32);
    sp = near_value(32'(tally.filt.src_port), 16);
    dp = near_value(32'(tally.filt.dst_port), 16);
    // ports first so a small IHL cannot overwrite the header fields
    frame_buf[tcp_at]     = sp[15:8];
    frame_buf[tcp_at + 1] = sp[7:0];
    frame_buf[tcp_at + 2] = dp[15:8];
    frame_buf[tcp_at + 3] = dp[7:0];
    for (int i = 0; i < 4; i++) begin
      frame_buf[LINK_HEADER_BYTES + 12 + i] = sa[31 - 8 * i -: 8];
      frame_buf[LINK_HEADER_BYTES + 16 + i] = da[31 - 8 * i -: 8];
    end
    frame_buf[LINK_HEADER_BYTES][3:0] = 4'(hdr_words);
    frame_buf[LINK_HEADER_BYTES + 9] =
      ($urandom_range(99) < 80) ? PROTO_TCP : 8'($urandom_range(255));
    // short frames end before the protocol byte or before the last port byte
    if (r < 25) len = $urandom_range(tcp_at + 3, 1);
    else len = tcp_at + 4 + $urandom_range(6);
  endtask

  initial begin
    int unsigned len, sent, frames;
    tally     = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_SRC_ADDR_EN;
    cfg_wdata = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: single-byte frame, then a TCP frame with IHL zero so the
    // port bytes overlap the IPv4 header, filters at their reset values
    send_byte(8'hFF, 1'b1);
    for (int i = 0; i < FRAME_BUF; i++) frame_buf[i] = 8'($urandom_range(255));
    frame_buf[LINK_HEADER_BYTES][3:0] = 4'd0;
    frame_buf[LINK_HEADER_BYTES + 9]  = PROTO_TCP;
    send_frame(LINK_HEADER_BYTES + 10);
    drain();

    // Random: three idling profiles, four filter settings each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 28; rx_idle_pct = 53; end
        1: begin tx_idle_pct = 53; rx_idle_pct = 28; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        apply_filter(filt_mode_e'(blk));
        if (blk == 1 && phase != 1) hold_reqs++;
        sent   = 0;
        frames = 0;
        while (sent < BLOCK_BYTES || frames < 2) begin
          build_frame(len);
          send_frame(len);
          sent += len;
          frames++;
        end
        drain();
      end
    end

    if (tally.errors == 0 && tally.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
